/* hdl/oaht_pkg.sv */
// ----------------------------------------------------------------------------
// oaht_pkg
// Shared types and constants of the open-addressing hash table unit.
// ----------------------------------------------------------------------------
package oaht_pkg;

   localparam int KEY_W     = 31;
   localparam int MOD_W     = 31;
   localparam int TS_W      = 7;
   localparam int CSR_AW    = 2;
   localparam int CSR_DW    = 31;
   localparam int DEPTH_DEF = 64;

   localparam logic [MOD_W-1:0] MOD_RESET = MOD_W'(61);
   localparam logic [TS_W-1:0]  TS_RESET  = TS_W'(64);

   // Reciprocal of ten for a 32-bit dividend: q = (h * RECIP10) >> RECIP10_SHIFT.
   localparam logic [31:0] RECIP10       = 32'hCCCC_CCCD;
   localparam int          RECIP10_SHIFT = 35;

   localparam logic [CSR_AW-1:0] CSR_PROBE_MODE = CSR_AW'(0);
   localparam logic [CSR_AW-1:0] CSR_MODULUS    = CSR_AW'(1);
   localparam logic [CSR_AW-1:0] CSR_TABLE_SIZE = CSR_AW'(2);

   localparam logic CMD_INSERT = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic MODE_LINEAR    = 1'b0;
   localparam logic MODE_QUADRATIC = 1'b1;

   typedef enum logic [2:0] {
      ST_HOME  = 3'd0,
      ST_COLL  = 3'd1,
      ST_DUP   = 3'd2,
      ST_FOUND = 3'd3,
      ST_MISS  = 3'd4,
      ST_FULL  = 3'd5
   } status_type;

endpackage

/* hdl/oaht_if.sv */
// ----------------------------------------------------------------------------
// oaht_req_if / oaht_rsp_if
// Valid/ready channels carrying request and response items.
// ----------------------------------------------------------------------------
interface oaht_req_if;
   logic                     valid;
   logic                     ready;
   logic                     cmd;
   logic [oaht_pkg::KEY_W-1:0] key;

   modport source (output valid, output cmd, output key, input ready);
   modport sink   (input valid, input cmd, input key, output ready);
endinterface

interface oaht_rsp_if #(
   parameter int POS_W = 6,
   parameter int PRB_W = 7
);
   logic                 valid;
   logic                 ready;
   oaht_pkg::status_type status;
   logic [POS_W-1:0]     position;
   logic [PRB_W-1:0]     probes;

   modport source (output valid, output status, output position, output probes,
                   input ready);
   modport sink   (input valid, input status, input position, input probes,
                   output ready);
endinterface

/* hdl/oaht_home_unit.sv */
// ----------------------------------------------------------------------------
// oaht_home_unit
// Computes the home slot of a key: a bit-serial remainder by the nonzero modulus,
// then repeated division by ten until the value is below the size in use.
// ----------------------------------------------------------------------------
module oaht_home_unit #(
   parameter  int DEPTH = oaht_pkg::DEPTH_DEF,
   localparam int AW    = $clog2(DEPTH),
   localparam int SW    = $clog2(DEPTH + 1)
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       start,
   input  logic [oaht_pkg::KEY_W-1:0] key,
   input  logic [oaht_pkg::MOD_W-1:0] modulus,
   input  logic [SW-1:0]              size,
   output logic                       done,
   output logic [AW-1:0]              home
);

   localparam int KW = oaht_pkg::KEY_W;
   localparam int CW = $clog2(KW);

   typedef enum logic [2:0] {
      H_IDLE = 3'b001,
      H_DIV  = 3'b010,
      H_TEN  = 3'b100
   } hstate_type;

   hstate_type     state_ff, state_in;
   logic [KW-1:0]  h_ff, h_in;
   logic [KW-1:0]  dvd_ff, dvd_in;
   logic [CW-1:0]  cnt_ff, cnt_in;
   logic [KW:0]    trial;
   logic [KW:0]    divisor;
   logic [63:0]    prod;
   logic [KW-1:0]  quot;

   always_comb begin
      trial    = {h_ff, dvd_ff[KW-1]};
      divisor  = {1'b0, modulus};
      prod     = 64'(h_ff) * 64'(oaht_pkg::RECIP10);
      quot     = KW'(prod >> oaht_pkg::RECIP10_SHIFT);
      state_in = state_ff;
      h_in     = h_ff;
      dvd_in   = dvd_ff;
      cnt_in   = cnt_ff;
      done     = 1'b0;
      unique case (state_ff)
         H_IDLE: begin
            if (start) begin
               if (modulus == '0) begin
                  h_in     = key;
                  state_in = H_TEN;
               end else begin
                  h_in     = '0;
                  dvd_in   = key;
                  cnt_in   = '0;
                  state_in = H_DIV;
               end
            end
         end
         H_DIV: begin
            if (trial >= divisor) begin
               h_in = KW'(trial - divisor);
            end else begin
               h_in = KW'(trial);
            end
            dvd_in = dvd_ff << 1;
            cnt_in = CW'(cnt_ff + 1'b1);
            if (cnt_ff == CW'(KW - 1)) begin
               state_in = H_TEN;
            end
         end
         H_TEN: begin
            if (h_ff >= KW'(size)) begin
               h_in = quot;
            end else begin
               done     = 1'b1;
               state_in = H_IDLE;
            end
         end
         default: begin
            state_in = H_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= H_IDLE;
      end else begin
         state_ff <= state_in;
      end
      h_ff   <= h_in;
      dvd_ff <= dvd_in;
      cnt_ff <= cnt_in;
   end

   assign home = h_ff[AW-1:0];

endmodule

/* hdl/open_addressing_hash_table_unit.sv */
// ----------------------------------------------------------------------------
// open_addressing_hash_table_unit
// Hash table of keys with open addressing and linear or quadratic probing.
// ----------------------------------------------------------------------------
// After reset the unit sweeps its slot memory to mark every slot free, during
// which no item is accepted; configuration writes are taken throughout. Items
// are then handled one at a time. An item is accepted, starts the hash, goes
// through the bit-serial remainder by the modulus (none when the modulus is
// zero), then through the divisions by ten and one more step to find the home
// slot, and then examines slots, each of which is read from the memory and
// checked in the following cycle. A finished item waits in the output
// register, and the next item is accepted meanwhile; while that register is
// still full, an item that is done with its probes waits before it leaves.
// ----------------------------------------------------------------------------
module open_addressing_hash_table_unit #(
   parameter  int DEPTH = oaht_pkg::DEPTH_DEF,
   localparam int AW    = $clog2(DEPTH),
   localparam int SW    = $clog2(DEPTH + 1)
) (
   input  logic                        clock,
   input  logic                        reset,
   oaht_req_if.sink                    req_bus,
   oaht_rsp_if.source                  rsp_bus,
   input  logic                        csr_we,
   input  logic [oaht_pkg::CSR_AW-1:0] csr_addr,
   input  logic [oaht_pkg::CSR_DW-1:0] csr_wdata
);

   localparam int KW  = oaht_pkg::KEY_W;
   localparam int TW  = oaht_pkg::TS_W;
   localparam int CLW = (SW > TW) ? SW : TW;

   typedef enum logic [4:0] {
      S_CLEAR = 5'b00001,
      S_IDLE  = 5'b00010,
      S_HASH  = 5'b00100,
      S_READ  = 5'b01000,
      S_CHECK = 5'b10000
   } state_type;

   state_type                  state_ff, state_in;
   logic                       mode_ff;
   logic [oaht_pkg::MOD_W-1:0] modulus_ff;
   logic [TW-1:0]              tsize_ff;

   logic                       cmd_ff, cmd_in;
   logic [KW-1:0]              key_ff, key_in;
   logic [SW-1:0]              size_ff, size_in;
   logic [AW-1:0]              slot_ff, slot_in;
   logic [SW-1:0]              idx_ff, idx_in;
   logic [SW-1:0]              step_ff, step_in;
   logic [AW-1:0]              clr_ff, clr_in;

   logic [KW:0]                mem [DEPTH];
   logic [KW:0]                rdata_ff;
   logic                       mem_we;
   logic [AW-1:0]              mem_waddr;
   logic [KW:0]                mem_wdata;

   logic                       rsp_valid_ff, rsp_valid_in;
   oaht_pkg::status_type       rsp_status_ff, res_status;
   logic [AW-1:0]              rsp_pos_ff, res_pos;
   logic [SW-1:0]              rsp_prb_ff, res_prb;

   logic                       hash_start;
   logic                       hash_done;
   logic [AW-1:0]              hash_home;

   logic                       accept;
   logic                       out_free;
   logic                       fire;
   logic                       used;
   logic                       hit;
   logic                       lookup;
   logic                       last;
   logic [SW:0]                sum;
   logic [SW:0]                step2;
   logic [CLW-1:0]             ts_wide;

   oaht_home_unit #(
      .DEPTH (DEPTH)
   ) u_home (
      .clock   (clock),
      .reset   (reset),
      .start   (hash_start),
      .key     (key_ff),
      .modulus (modulus_ff),
      .size    (size_ff),
      .done    (hash_done),
      .home    (hash_home)
   );

   assign req_bus.ready = (state_ff == S_IDLE);
   assign accept        = req_bus.valid && (state_ff == S_IDLE);
   assign out_free      = !rsp_valid_ff || rsp_bus.ready;

   always_comb begin
      ts_wide = CLW'(tsize_ff);
      if (ts_wide == '0) begin
         size_in = SW'(1);
      end else if (ts_wide > CLW'(DEPTH)) begin
         size_in = SW'(DEPTH);
      end else begin
         size_in = SW'(ts_wide);
      end
   end

   always_comb begin
      used       = rdata_ff[KW];
      hit        = (rdata_ff[KW-1:0] == key_ff);
      lookup     = (cmd_ff == oaht_pkg::CMD_LOOKUP);
      last       = ((SW + 1)'(idx_ff) + 1'b1) >= (SW + 1)'(size_ff);
      sum        = (SW + 1)'(slot_ff) + (SW + 1)'(step_ff);
      step2      = (SW + 1)'(step_ff) + (SW + 1)'(2);
      state_in   = state_ff;
      cmd_in     = cmd_ff;
      key_in     = key_ff;
      slot_in    = slot_ff;
      idx_in     = idx_ff;
      step_in    = step_ff;
      clr_in     = clr_ff;
      hash_start = 1'b0;
      mem_we     = 1'b0;
      mem_waddr  = slot_ff;
      mem_wdata  = {1'b1, key_ff};
      fire       = 1'b0;
      res_status = oaht_pkg::ST_MISS;
      res_pos    = '0;
      res_prb    = idx_ff;

      if (!used) begin
         if (lookup) begin
            res_status = oaht_pkg::ST_MISS;
         end else begin
            res_status = (idx_ff == '0) ? oaht_pkg::ST_HOME : oaht_pkg::ST_COLL;
            res_pos    = slot_ff;
         end
      end else if (hit) begin
         res_status = lookup ? oaht_pkg::ST_FOUND : oaht_pkg::ST_DUP;
         res_pos    = slot_ff;
      end else begin
         res_status = lookup ? oaht_pkg::ST_MISS : oaht_pkg::ST_FULL;
      end

      unique case (state_ff)
         S_CLEAR: begin
            mem_we    = 1'b1;
            mem_waddr = clr_ff;
            mem_wdata = '0;
            clr_in    = AW'(clr_ff + 1'b1);
            if (clr_ff == AW'(DEPTH - 1)) begin
               state_in = S_IDLE;
            end
         end
         S_IDLE: begin
            if (accept) begin
               cmd_in     = req_bus.cmd;
               key_in     = req_bus.key;
               state_in   = S_HASH;
            end
         end
         S_HASH: begin
            hash_start = !hash_done;
            if (hash_done) begin
               slot_in  = hash_home;
               idx_in   = '0;
               step_in  = SW'(1);
               state_in = S_READ;
            end
         end
         S_READ: begin
            state_in = S_CHECK;
         end
         S_CHECK: begin
            if (!used || hit || last) begin
               if (out_free) begin
                  fire     = 1'b1;
                  mem_we   = !used && !lookup;
                  state_in = S_IDLE;
               end
            end else begin
               slot_in = (sum >= (SW + 1)'(size_ff)) ? AW'(sum - (SW + 1)'(size_ff))
                                                     : AW'(sum);
               idx_in  = SW'(idx_ff + 1'b1);
               if (mode_ff == oaht_pkg::MODE_QUADRATIC) begin
                  step_in = (step2 >= (SW + 1)'(size_ff))
                            ? SW'(step2 - (SW + 1)'(size_ff)) : SW'(step2);
               end
               state_in = S_READ;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      if (accept) begin
         step_in = '0;
      end
   end

   assign rsp_valid_in = fire || (rsp_valid_ff && !rsp_bus.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_CLEAR;
         clr_ff       <= '0;
         rsp_valid_ff <= 1'b0;
         mode_ff      <= oaht_pkg::MODE_LINEAR;
         modulus_ff   <= oaht_pkg::MOD_RESET;
         tsize_ff     <= oaht_pkg::TS_RESET;
      end else begin
         state_ff     <= state_in;
         clr_ff       <= clr_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            unique case (csr_addr)
               oaht_pkg::CSR_PROBE_MODE: mode_ff    <= csr_wdata[0];
               oaht_pkg::CSR_MODULUS:    modulus_ff <= csr_wdata[oaht_pkg::MOD_W-1:0];
               oaht_pkg::CSR_TABLE_SIZE: tsize_ff   <= csr_wdata[TW-1:0];
               default: begin
               end
            endcase
         end
      end
      cmd_ff  <= cmd_in;
      key_ff  <= key_in;
      slot_ff <= slot_in;
      idx_ff  <= idx_in;
      step_ff <= step_in;
      if (accept) begin
         size_ff <= size_in;
      end
      if (fire) begin
         rsp_status_ff <= res_status;
         rsp_pos_ff    <= res_pos;
         rsp_prb_ff    <= res_prb;
      end
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      rdata_ff <= mem[slot_ff];
   end

   assign rsp_bus.valid    = rsp_valid_ff;
   assign rsp_bus.status   = rsp_status_ff;
   assign rsp_bus.position = rsp_pos_ff;
   assign rsp_bus.probes   = rsp_prb_ff;

endmodule
